[sv/converter_soft_start_sequencer_core_assert.svh]
// ----------------------------------------------------------------------------
// Soft-start sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef CONVERTER_SOFT_START_SEQUENCER_CORE_ASSERT_SVH
`define CONVERTER_SOFT_START_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication
`define CSS_AST_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("soft-start sequencer check failed");

// Next-cycle implication
`define CSS_AST_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("soft-start sequencer check failed");

`endif

[sv/css_pkg.sv]
// ----------------------------------------------------------------------------
// Soft-start sequencer package
// Types, register indexes and phase codes shared by the sequencer files.
// ----------------------------------------------------------------------------
package css_pkg;

  localparam int TARGET_W = 12;
  localparam int REF_W    = 16;
  localparam int DELAY_W  = 16;
  localparam int STEP_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ON_DELAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOOD_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SELF_START = 2'd3;

  // Configuration reset values
  localparam logic [DELAY_W-1:0] ON_DELAY_RST   = 16'd500;
  localparam logic [DELAY_W-1:0] GOOD_DELAY_RST = 16'd200;
  localparam logic [STEP_W-1:0]  RAMP_STEP_RST  = 8'd4;

  typedef enum logic [2:0] {
    PH_INIT       = 3'd0,
    PH_LAUNCH     = 3'd1,
    PH_STANDBY    = 3'd2,
    PH_ON_DELAY   = 3'd3,
    PH_RAMP       = 3'd4,
    PH_GOOD_DELAY = 3'd5,
    PH_COMPLETE   = 3'd6,
    PH_FAULT      = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_OFF      = 3'd0,
    ST_STANDBY  = 3'd1,
    ST_STARTING = 3'd2,
    ST_ON       = 3'd3,
    ST_FAULT    = 3'd4
  } status_t;

  typedef struct packed {
    logic en;
    logic go;
    logic adc;
    logic fault;
  } flags_t;

  typedef struct packed {
    logic [DELAY_W-1:0] on_delay;
    logic [DELAY_W-1:0] good_delay;
    logic [STEP_W-1:0]  ramp_step;
    logic               self_start;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [DELAY_W-1:0] tick;
    logic [REF_W-1:0]   ramp;
    logic               use_ramp;
    logic               pwm_en;
    logic               loop_en;
    flags_t             flags;
  } seq_state_t;

  typedef struct packed {
    logic [TARGET_W-1:0] target_ref;
    logic                adc_seen;
    logic                enable_level;
    logic                go_request;
    logic                set_fault;
    logic                clear_fault;
    logic                force_fault;
  } tick_word_t;

  typedef struct packed {
    status_t          run_status;
    phase_t           phase_now;
    logic             pwm_on;
    logic             loop_on;
    logic [REF_W-1:0] control_ref;
    logic             fault_flag;
    logic             adc_flag;
    logic             go_flag;
  } result_word_t;

endpackage

[sv/css_if.sv]
// ----------------------------------------------------------------------------
// Soft-start sequencer channels
// Valid/ready channels for tick words in and status words out.
// ----------------------------------------------------------------------------
interface css_in_if;
  import css_pkg::*;

  logic                valid;
  logic                ready;
  logic [TARGET_W-1:0] target_ref;
  logic                adc_seen;
  logic                enable_level;
  logic                go_request;
  logic                set_fault;
  logic                clear_fault;
  logic                force_fault;

  modport source (
    output valid, target_ref, adc_seen, enable_level, go_request,
           set_fault, clear_fault, force_fault,
    input  ready
  );
  modport sink (
    input  valid, target_ref, adc_seen, enable_level, go_request,
           set_fault, clear_fault, force_fault,
    output ready
  );
endinterface

interface css_out_if;
  import css_pkg::*;

  logic             valid;
  logic             ready;
  logic [2:0]       run_status;
  logic [2:0]       phase_now;
  logic             pwm_on;
  logic             loop_on;
  logic [REF_W-1:0] control_ref;
  logic             fault_flag;
  logic             adc_flag;
  logic             go_flag;

  modport source (
    output valid, run_status, phase_now, pwm_on, loop_on, control_ref,
           fault_flag, adc_flag, go_flag,
    input  ready
  );
  modport sink (
    input  valid, run_status, phase_now, pwm_on, loop_on, control_ref,
           fault_flag, adc_flag, go_flag,
    output ready
  );
endinterface

[sv/css_cfg.sv]
// ----------------------------------------------------------------------------
// Soft-start sequencer configuration registers
// Holds delays, ramp step and auto-start, written through a plain port.
// ----------------------------------------------------------------------------
module css_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [css_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [css_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output css_pkg::cfg_t                      cfg
);
  import css_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write onto the addressed register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_ON_DELAY:   cfg_nxt.on_delay   = cfg_wdata[DELAY_W-1:0];
        REG_GOOD_DELAY: cfg_nxt.good_delay = cfg_wdata[DELAY_W-1:0];
        REG_RAMP_STEP:  cfg_nxt.ramp_step  = cfg_wdata[STEP_W-1:0];
        REG_SELF_START: cfg_nxt.self_start = cfg_wdata[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_delay   <= ON_DELAY_RST;
      cfg_r.good_delay <= GOOD_DELAY_RST;
      cfg_r.ramp_step  <= RAMP_STEP_RST;
      cfg_r.self_start <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/css_step.sv]
// ----------------------------------------------------------------------------
// Soft-start sequencer tick logic
// Combinational update of phase, counters, ramp and flags for one tick.
// ----------------------------------------------------------------------------
module css_step (
  input  css_pkg::seq_state_t   st,
  input  css_pkg::tick_word_t   tw,
  input  css_pkg::cfg_t         cfg,
  output css_pkg::seq_state_t   st_nxt,
  output css_pkg::result_word_t res
);
  import css_pkg::*;

  flags_t             fl_in;
  phase_t             ph_in;
  logic [DELAY_W-1:0] tick_inc;
  logic [REF_W:0]     ramp_sum;
  logic [REF_W-1:0]   ramp_sat;
  status_t            status;

  // Apply the request bits to the flags ahead of the tick
  always_comb begin
    fl_in     = st.flags;
    fl_in.en  = tw.enable_level | (st.flags.en & cfg.self_start);
    fl_in.adc = st.flags.adc | tw.adc_seen;
    fl_in.go  = st.flags.go | tw.go_request;
    if (tw.clear_fault) fl_in.fault = 1'b0;
    if (tw.set_fault)   fl_in.fault = 1'b1;
  end

  assign ph_in    = tw.force_fault ? PH_FAULT : st.phase;
  assign tick_inc = st.tick + DELAY_W'(1);
  assign ramp_sum = {1'b0, st.ramp} + {{(REF_W + 1 - STEP_W){1'b0}}, cfg.ramp_step};
  assign ramp_sat = ramp_sum[REF_W] ? {REF_W{1'b1}} : ramp_sum[REF_W-1:0];

  // Advance the phase sequence
  always_comb begin
    st_nxt       = st;
    st_nxt.flags = fl_in;
    status       = ST_OFF;
    case (ph_in)
      PH_INIT: begin
        st_nxt.tick     = '0;
        st_nxt.ramp     = '0;
        st_nxt.use_ramp = 1'b0;
        st_nxt.loop_en  = 1'b0;
        st_nxt.phase    = PH_LAUNCH;
      end
      PH_LAUNCH: begin
        st_nxt.phase = PH_STANDBY;
      end
      PH_STANDBY: begin
        status         = ST_STANDBY;
        st_nxt.pwm_en  = 1'b0;
        st_nxt.loop_en = 1'b0;
        if (fl_in.en && fl_in.adc && fl_in.go && !fl_in.fault) begin
          st_nxt.tick  = '0;
          st_nxt.phase = PH_ON_DELAY;
        end
      end
      PH_ON_DELAY: begin
        status      = ST_STARTING;
        st_nxt.tick = tick_inc;
        if (st.tick > cfg.on_delay) begin
          st_nxt.ramp     = '0;
          st_nxt.use_ramp = 1'b1;
          st_nxt.tick     = '0;
          st_nxt.phase    = PH_RAMP;
        end
      end
      PH_RAMP: begin
        status         = ST_STARTING;
        st_nxt.pwm_en  = 1'b1;
        st_nxt.loop_en = 1'b1;
        st_nxt.ramp    = ramp_sat;
        if (ramp_sat >= {{(REF_W - TARGET_W){1'b0}}, tw.target_ref}) begin
          st_nxt.tick  = '0;
          st_nxt.phase = PH_GOOD_DELAY;
        end
      end
      PH_GOOD_DELAY: begin
        status      = ST_STARTING;
        st_nxt.tick = tick_inc;
        if (st.tick > cfg.good_delay) begin
          st_nxt.tick  = '0;
          st_nxt.phase = PH_COMPLETE;
        end
      end
      PH_COMPLETE: begin
        status          = ST_ON;
        st_nxt.use_ramp = 1'b0;
      end
      PH_FAULT: begin
        status             = ST_FAULT;
        st_nxt.flags.fault = 1'b1;
        st_nxt.flags.adc   = 1'b0;
        st_nxt.phase       = PH_STANDBY;
      end
      default: begin
        status             = ST_FAULT;
        st_nxt.flags.fault = 1'b1;
        st_nxt.flags.adc   = 1'b0;
        st_nxt.phase       = PH_STANDBY;
      end
    endcase
    // Auto-start holds enable and go; otherwise go drops after each tick
    if (cfg.self_start) begin
      st_nxt.flags.en = 1'b1;
      st_nxt.flags.go = 1'b1;
    end else begin
      st_nxt.flags.go = 1'b0;
    end
  end

  // Build the status word
  always_comb begin
    res.run_status  = status;
    res.phase_now   = st_nxt.phase;
    res.pwm_on      = st_nxt.pwm_en;
    res.loop_on     = st_nxt.loop_en;
    res.control_ref = st_nxt.use_ramp ? st_nxt.ramp
                                      : {{(REF_W - TARGET_W){1'b0}}, tw.target_ref};
    res.fault_flag  = st_nxt.flags.fault;
    res.adc_flag    = st_nxt.flags.adc;
    res.go_flag     = st_nxt.flags.go;
  end

endmodule

[sv/converter_soft_start_sequencer_core.sv]
// ----------------------------------------------------------------------------
// Converter soft-start sequencer core
// Steps the converter start-up phases once for every scheduler tick word.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one tick word per scheduler tick (target, ADC seen, enable,
//   go, fault set/clear/force). out_ch returns one status word per tick:
//   status, phase, PWM and loop enables, loop reference and flags.
//   cfg_we/cfg_idx/cfg_wdata write the delays, ramp step and auto-start;
//   write them only while no tick word is in flight.
// Pipeline:
//   A tick word is captured in the input register, then updated against the
//   sequencer state into the output register when the output is free or
//   draining. One word per cycle is sustained while out_ch.ready stays high;
//   the state update is combinational between the two registers.
// Reset:
//   rst_n (synchronous, low) empties both registers, puts the phase to init,
//   clears counters, ramp and flags, and loads the register defaults.
// Stall:
//   While out_ch.ready is low the status word holds; one more tick word waits
//   in the input register, then in_ch.ready drops until the output drains.
// ----------------------------------------------------------------------------
module converter_soft_start_sequencer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [css_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [css_pkg::CFG_DATA_W-1:0] cfg_wdata,
  css_in_if.sink                         in_ch,
  css_out_if.source                      out_ch
);
  import css_pkg::*;

  cfg_t         cfg;
  tick_word_t   tw_in;
  tick_word_t   tw_r;
  logic         tw_vld_r;
  seq_state_t   st_r;
  seq_state_t   st_nxt;
  result_word_t res_nxt;
  result_word_t res_r;
  logic         res_vld_r;
  logic         advance;

  css_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  css_step u_step (
    .st     (st_r),
    .tw     (tw_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Pack the incoming word
  always_comb begin
    tw_in.target_ref   = in_ch.target_ref;
    tw_in.adc_seen     = in_ch.adc_seen;
    tw_in.enable_level = in_ch.enable_level;
    tw_in.go_request   = in_ch.go_request;
    tw_in.set_fault    = in_ch.set_fault;
    tw_in.clear_fault  = in_ch.clear_fault;
    tw_in.force_fault  = in_ch.force_fault;
  end

  // Move the held tick into the output when the output is free or draining
  assign advance     = tw_vld_r && (!res_vld_r || out_ch.ready);
  assign in_ch.ready = !tw_vld_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      tw_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      tw_r <= tw_in;
    end
  end

  // Sequencer state, updated once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase    <= PH_INIT;
      st_r.tick     <= '0;
      st_r.ramp     <= '0;
      st_r.use_ramp <= 1'b0;
      st_r.pwm_en   <= 1'b0;
      st_r.loop_en  <= 1'b0;
      st_r.flags    <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  // Drive the result channel
  assign out_ch.valid       = res_vld_r;
  assign out_ch.run_status  = res_r.run_status;
  assign out_ch.phase_now   = res_r.phase_now;
  assign out_ch.pwm_on      = res_r.pwm_on;
  assign out_ch.loop_on     = res_r.loop_on;
  assign out_ch.control_ref = res_r.control_ref;
  assign out_ch.fault_flag  = res_r.fault_flag;
  assign out_ch.adc_flag    = res_r.adc_flag;
  assign out_ch.go_flag     = res_r.go_flag;

`include "converter_soft_start_sequencer_core_assert.svh"

  // The fault phase is left within the tick that enters it
  `CSS_AST_IMP(a_fault_not_kept, 1'b1, st_r.phase != PH_FAULT)
  // PWM release and loop enable move together
  `CSS_AST_IMP(a_pwm_loop_pair, 1'b1, st_r.pwm_en == st_r.loop_en)
  // A moved tick shows up as a valid word carrying the new phase
  `CSS_AST_NXT(a_result_phase, advance, res_vld_r && (res_r.phase_now == st_r.phase))
  // A held tick never waits behind an empty output
  `CSS_AST_IMP(a_no_bubble, tw_vld_r && !res_vld_r, advance)

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Soft-start sequencer core testbench
// Drives tick words through the valid/ready input channel and checks every
// status word against a cycle-free model of the start-up sequence. A short
// scripted run covers reset, fault handling, zero and maximum delays, a zero
// ramp step and auto-start. Random runs under several register settings
// follow, with random idle cycles on both channels in all runs but one.
// ----------------------------------------------------------------------------
module tb;
  import css_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 35;
  localparam int RUNS         = 6;
  localparam int TICKS_PER_RUN = 75;

  typedef struct {
    logic                  is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    tick_word_t            w;
    logic                  typed;
    result_word_t          want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic no_idle;

  css_in_if  in_ch ();
  css_out_if out_ch ();

  converter_soft_start_sequencer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow copy of the sequencer and its registers
  seq_state_t shadow_seq;
  cfg_t       shadow_cfg;

  result_word_t pending_status[$];
  script_row_t  start_script[$];
  int errors      = 0;
  int words_seen  = 0;
  int cycle_count = 0;

  always #10 clk = ~clk;

  // Work out the status word of one tick and advance the shadow state
  function automatic result_word_t next_status_word(input tick_word_t w);
    result_word_t r;
    status_t      st;
    logic         keep_en;
    logic         done;
    logic [16:0]  sum;
    st = ST_OFF;
    keep_en = shadow_seq.flags.en && shadow_cfg.self_start;
    shadow_seq.flags.en = w.enable_level || keep_en;
    if (w.adc_seen) shadow_seq.flags.adc = 1'b1;
    if (w.go_request) shadow_seq.flags.go = 1'b1;
    if (w.clear_fault) shadow_seq.flags.fault = 1'b0;
    if (w.set_fault) shadow_seq.flags.fault = 1'b1;
    if (w.force_fault) shadow_seq.phase = PH_FAULT;
    case (shadow_seq.phase)
      PH_INIT: begin
        shadow_seq.tick     = '0;
        shadow_seq.ramp     = '0;
        shadow_seq.use_ramp = 1'b0;
        shadow_seq.loop_en  = 1'b0;
        st = ST_OFF;
        shadow_seq.phase = PH_LAUNCH;
      end
      PH_LAUNCH: begin
        st = ST_OFF;
        shadow_seq.phase = PH_STANDBY;
      end
      PH_STANDBY: begin
        st = ST_STANDBY;
        shadow_seq.pwm_en  = 1'b0;
        shadow_seq.loop_en = 1'b0;
        if (shadow_seq.flags.en && shadow_seq.flags.adc && shadow_seq.flags.go &&
            !shadow_seq.flags.fault) begin
          shadow_seq.tick  = '0;
          shadow_seq.phase = PH_ON_DELAY;
        end
      end
      PH_ON_DELAY: begin
        st = ST_STARTING;
        done = shadow_seq.tick > shadow_cfg.on_delay;
        shadow_seq.tick = shadow_seq.tick + 16'd1;
        if (done) begin
          shadow_seq.ramp     = '0;
          shadow_seq.use_ramp = 1'b1;
          shadow_seq.tick     = '0;
          shadow_seq.phase    = PH_RAMP;
        end
      end
      PH_RAMP: begin
        st = ST_STARTING;
        shadow_seq.pwm_en  = 1'b1;
        shadow_seq.loop_en = 1'b1;
        // Saturate the ramp at full scale
        sum = {1'b0, shadow_seq.ramp} + {9'd0, shadow_cfg.ramp_step};
        shadow_seq.ramp = sum[16] ? 16'hFFFF : sum[15:0];
        if (shadow_seq.ramp >= {4'd0, w.target_ref}) begin
          shadow_seq.tick  = '0;
          shadow_seq.phase = PH_GOOD_DELAY;
        end
      end
      PH_GOOD_DELAY: begin
        st = ST_STARTING;
        done = shadow_seq.tick > shadow_cfg.good_delay;
        shadow_seq.tick = shadow_seq.tick + 16'd1;
        if (done) begin
          shadow_seq.tick  = '0;
          shadow_seq.phase = PH_COMPLETE;
        end
      end
      PH_COMPLETE: begin
        st = ST_ON;
        shadow_seq.use_ramp = 1'b0;
      end
      default: begin
        st = ST_FAULT;
        shadow_seq.flags.fault = 1'b1;
        shadow_seq.flags.adc   = 1'b0;
        shadow_seq.phase       = PH_STANDBY;
      end
    endcase
    if (shadow_cfg.self_start) begin
      shadow_seq.flags.en = 1'b1;
      shadow_seq.flags.go = 1'b1;
    end else begin
      shadow_seq.flags.go = 1'b0;
    end
    r.run_status  = st;
    r.phase_now   = shadow_seq.phase;
    r.pwm_on      = shadow_seq.pwm_en;
    r.loop_on     = shadow_seq.loop_en;
    r.control_ref = shadow_seq.use_ramp ? shadow_seq.ramp : {4'd0, w.target_ref};
    r.fault_flag  = shadow_seq.flags.fault;
    r.adc_flag    = shadow_seq.flags.adc;
    r.go_flag     = shadow_seq.flags.go;
    return r;
  endfunction

  function automatic tick_word_t tw(input int target, input bit adc, input bit en,
                                    input bit go, input bit setf, input bit clrf,
                                    input bit frc);
    tick_word_t w;
    w.target_ref   = TARGET_W'(target);
    w.adc_seen     = adc;
    w.enable_level = en;
    w.go_request   = go;
    w.set_fault    = setf;
    w.clear_fault  = clrf;
    w.force_fault  = frc;
    return w;
  endfunction

  function automatic result_word_t rw(input status_t st, input phase_t ph,
                                      input bit pwm, input bit lp, input int ctrl,
                                      input bit flt, input bit adc, input bit go);
    result_word_t r;
    r.run_status  = st;
    r.phase_now   = ph;
    r.pwm_on      = pwm;
    r.loop_on     = lp;
    r.control_ref = REF_W'(ctrl);
    r.fault_flag  = flt;
    r.adc_flag    = adc;
    r.go_flag     = go;
    return r;
  endfunction

  function automatic void put_check(input tick_word_t w, input result_word_t want);
    script_row_t row;
    row.is_reg = 1'b0;
    row.idx    = '0;
    row.data   = '0;
    row.w      = w;
    row.typed  = 1'b1;
    row.want   = want;
    start_script.push_back(row);
  endfunction

  function automatic void put_tick(input tick_word_t w);
    script_row_t row;
    row.is_reg = 1'b0;
    row.idx    = '0;
    row.data   = '0;
    row.w      = w;
    row.typed  = 1'b0;
    row.want   = '0;
    start_script.push_back(row);
  endfunction

  function automatic void put_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    script_row_t row;
    row.is_reg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    row.w      = '0;
    row.typed  = 1'b0;
    row.want   = '0;
    start_script.push_back(row);
  endfunction

  task automatic flag_mismatch(input string field, input int unsigned got,
                               input int unsigned want);
    $display("mismatch at status word %0d: %s got 'h%0h want 'h%0h",
             words_seen, field, got, want);
    errors++;
  endtask

  // Write one register while the sequencer is idle and mirror it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ON_DELAY:   shadow_cfg.on_delay   = data;
      REG_GOOD_DELAY: shadow_cfg.good_delay = data;
      REG_RAMP_STEP:  shadow_cfg.ramp_step  = data[STEP_W-1:0];
      REG_SELF_START: shadow_cfg.self_start = data[0];
      default: ;
    endcase
  endtask

  // Drop valid and wait until every status word has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Offer one tick word, hold it until accepted, then queue its status word
  task automatic send_tick(input tick_word_t w, input logic typed,
                           input result_word_t fixed);
    result_word_t calc;
    if (!no_idle) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.target_ref   <= w.target_ref;
    in_ch.adc_seen     <= w.adc_seen;
    in_ch.enable_level <= w.enable_level;
    in_ch.go_request   <= w.go_request;
    in_ch.set_fault    <= w.set_fault;
    in_ch.clear_fault  <= w.clear_fault;
    in_ch.force_fault  <= w.force_fault;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    calc = next_status_word(w);
    pending_status.push_back(typed ? fixed : calc);
  endtask

  // Stall the result channel at random
  always @(posedge clk) begin
    if (no_idle) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Check each accepted status word against the oldest expectation
  always @(posedge clk) begin
    result_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_status.size() == 0) begin
        flag_mismatch("unexpected word, phase_now", out_ch.phase_now, 0);
      end else begin
        want = pending_status.pop_front();
        if (out_ch.run_status !== want.run_status)
          flag_mismatch("run_status", out_ch.run_status, want.run_status);
        if (out_ch.phase_now !== want.phase_now)
          flag_mismatch("phase_now", out_ch.phase_now, want.phase_now);
        if (out_ch.pwm_on !== want.pwm_on)
          flag_mismatch("pwm_on", out_ch.pwm_on, want.pwm_on);
        if (out_ch.loop_on !== want.loop_on)
          flag_mismatch("loop_on", out_ch.loop_on, want.loop_on);
        if (out_ch.control_ref !== want.control_ref)
          flag_mismatch("control_ref", out_ch.control_ref, want.control_ref);
        if (out_ch.fault_flag !== want.fault_flag)
          flag_mismatch("fault_flag", out_ch.fault_flag, want.fault_flag);
        if (out_ch.adc_flag !== want.adc_flag)
          flag_mismatch("adc_flag", out_ch.adc_flag, want.adc_flag);
        if (out_ch.go_flag !== want.go_flag)
          flag_mismatch("go_flag", out_ch.go_flag, want.go_flag);
      end
      words_seen++;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("converter_soft_start_sequencer_core regression: fail");
      $finish;
    end
  end

  initial begin
    tick_word_t  w;
    script_row_t row;
    logic [TARGET_W-1:0] held;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    no_idle   = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.target_ref   = '0;
    in_ch.adc_seen     = 1'b0;
    in_ch.enable_level = 1'b0;
    in_ch.go_request   = 1'b0;
    in_ch.set_fault    = 1'b0;
    in_ch.clear_fault  = 1'b0;
    in_ch.force_fault  = 1'b0;
    held = '0;

    shadow_seq       = '0;
    shadow_seq.phase = PH_INIT;
    shadow_cfg.on_delay   = ON_DELAY_RST;
    shadow_cfg.good_delay = GOOD_DELAY_RST;
    shadow_cfg.ramp_step  = RAMP_STEP_RST;
    shadow_cfg.self_start = 1'b0;

    // Scripted start-up: short delays and a coarse ramp
    put_reg(REG_ON_DELAY, 16'd0);
    put_reg(REG_GOOD_DELAY, 16'd0);
    put_reg(REG_RAMP_STEP, 16'd255);
    put_reg(REG_SELF_START, 16'd0);
    put_check(tw(4095, 0, 0, 0, 0, 0, 0), rw(ST_OFF, PH_LAUNCH, 0, 0, 4095, 0, 0, 0));
    put_check(tw(0, 0, 0, 0, 0, 0, 0), rw(ST_OFF, PH_STANDBY, 0, 0, 0, 0, 0, 0));
    // Enable alone does not leave standby
    put_check(tw('hAAA, 0, 1, 0, 0, 0, 0),
              rw(ST_STANDBY, PH_STANDBY, 0, 0, 'hAAA, 0, 0, 0));
    // Set and clear together: set wins and blocks the start
    put_check(tw('h555, 1, 1, 1, 1, 1, 0),
              rw(ST_STANDBY, PH_STANDBY, 0, 0, 'h555, 1, 1, 0));
    put_check(tw(1000, 0, 1, 1, 0, 1, 0),
              rw(ST_STANDBY, PH_ON_DELAY, 0, 0, 1000, 0, 1, 0));
    // Zero power-on delay, ramp to target, zero power-good delay, complete
    repeat (9) put_tick(tw(1000, 0, 1, 0, 0, 0, 0));
    // Forced fault keeps the PWM and loop enables
    put_check(tw(2000, 0, 1, 0, 0, 0, 1),
              rw(ST_FAULT, PH_STANDBY, 1, 1, 2000, 1, 0, 0));
    put_tick(tw(2000, 1, 1, 1, 0, 0, 0));
    put_tick(tw(0, 0, 0, 1, 0, 1, 0));
    put_tick(tw(0, 1, 1, 1, 0, 1, 0));
    put_tick(tw(0, 0, 1, 0, 0, 0, 0));
    put_tick(tw(0, 0, 1, 0, 0, 0, 0));
    // Zero ramp step finishes only on a zero target
    put_reg(REG_RAMP_STEP, 16'd0);
    put_tick(tw(0, 0, 1, 0, 0, 0, 0));
    // Full-scale power-good delay never ends
    put_reg(REG_GOOD_DELAY, 16'hFFFF);
    put_tick(tw(0, 0, 1, 0, 0, 0, 0));
    // Auto-start holds enable and go across a fault
    put_reg(REG_ON_DELAY, 16'hFFFF);
    put_reg(REG_SELF_START, 16'd1);
    put_tick(tw(4095, 0, 1, 0, 0, 0, 1));
    put_tick(tw(4095, 1, 0, 0, 0, 1, 0));
    put_tick(tw(4095, 0, 0, 0, 0, 0, 0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the script
    while (start_script.size() != 0) begin
      row = start_script.pop_front();
      if (row.is_reg) begin
        settle();
        write_reg(row.idx, row.data);
      end else begin
        send_tick(row.w, row.typed, row.want);
      end
    end

    // Random runs, each under its own register setting
    for (int p = 0; p < RUNS; p++) begin
      settle();
      no_idle <= (p == 2);
      write_reg(REG_ON_DELAY, CFG_DATA_W'(($urandom_range(0, 7) == 0) ?
                $urandom_range(0, 65535) : $urandom_range(0, 24)));
      write_reg(REG_GOOD_DELAY, CFG_DATA_W'(($urandom_range(0, 7) == 0) ?
                $urandom_range(0, 65535) : $urandom_range(0, 24)));
      write_reg(REG_RAMP_STEP, CFG_DATA_W'((p == 0) ? 1 :
                (p == 1) ? 255 : $urandom_range(1, 255)));
      write_reg(REG_SELF_START, CFG_DATA_W'(p % 2));
      for (int i = 0; i < TICKS_PER_RUN; i++) begin
        // Hold the target for a while, mostly small so ramps finish
        if ($urandom_range(0, 9) == 0) begin
          held = TARGET_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                        : $urandom_range(0, 400));
        end
        w.target_ref   = ($urandom_range(0, 19) == 0) ?
                         TARGET_W'($urandom_range(0, 4095)) : held;
        w.adc_seen     = ($urandom_range(0, 99) < 70);
        w.enable_level = ($urandom_range(0, 99) < 92);
        w.go_request   = ($urandom_range(0, 99) < 50);
        w.set_fault    = ($urandom_range(0, 99) < 3);
        w.clear_fault  = ($urandom_range(0, 99) < 35);
        w.force_fault  = ($urandom_range(0, 99) < 2);
        send_tick(w, 1'b0, '0);
      end
    end

    settle();
    if (errors == 0) begin
      $display("converter_soft_start_sequencer_core regression: pass");
    end else begin
      $display("converter_soft_start_sequencer_core regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/css_pkg.sv
sv/css_if.sv
sv/css_cfg.sv
sv/css_step.sv
sv/converter_soft_start_sequencer_core.sv
tb/sv/tb.sv
